// ----- hw/rtl/tccw_pkg.sv -----
// Shared types and constants for the text console character writer.
// Depends on nothing; imported by the writer, its checker and the bench.
`timescale 1ns / 1ps

package tccw_pkg;

   localparam int OPCODE_W  = 2;
   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int COL_OUT_W = 7;
   localparam int ROW_OUT_W = 5;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = ATTR_W + CHAR_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd127;

   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

endpackage

// ----- hw/rtl/tccw_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/text_console_char_writer.sv -----
// Text console character writer: cell store, cursor, scroll and clear sequencer.
// Depends on tccw_pkg and tccw_ram.
// Throughput: one word at a time; input stalls until the result is registered.
// Reset: sweeps zeros through all COLUMNS*ROWS cells, one per cycle, before the
// first word is taken; the attribute register loads 0x07 and the cursor homes.
`timescale 1ns / 1ps

module text_console_char_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tccw_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [tccw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tccw_pkg::INDEX_W-1:0]     req_cell_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tccw_pkg::COL_OUT_W-1:0]   rsp_cursor_col,
   output logic [tccw_pkg::ROW_OUT_W-1:0]   rsp_cursor_row,
   output logic [tccw_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic                             rsp_scrolled,
   input  logic                             csr_wr_en,
   input  logic [tccw_pkg::ATTR_W-1:0]      csr_wr_data
);

   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(COLUMNS + 1);
   localparam int RW         = $clog2(ROWS + 1);
   localparam int COPY_LAST  = COLUMNS * (ROWS - 1) - 1;
   localparam int CELL_LAST  = CELL_COUNT - 1;
   localparam int TAB_LAST   = (COLUMNS - 1) / TAB_STOP;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SCROLL,
      S_FILL,
      S_CLEAR,
      S_EMIT
   } state_type;

   state_type              state_ff;
   opcode_type             op_ff;
   logic [CHAR_W-1:0]      ch_ff;
   logic [INDEX_W-1:0]     idx_ff;
   logic [ATTR_W-1:0]      attr_ff;
   logic [CW-1:0]          col_ff;
   logic [RW-1:0]          row_ff;
   logic [ADDR_W-1:0]      cnt_ff;
   logic                   cp_vld_ff;
   logic [ADDR_W-1:0]      cp_addr_ff;
   logic [CELL_W-1:0]      cell_ff;
   logic                   scrolled_ff;
   logic                   rsp_valid_ff;
   logic [COL_OUT_W-1:0]   rsp_col_ff;
   logic [ROW_OUT_W-1:0]   rsp_row_ff;
   logic [CELL_W-1:0]      rsp_cell_ff;
   logic                   rsp_scrolled_ff;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [CELL_W-1:0]      ram_wr_data;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [CELL_W-1:0]      ram_rd_data;

   logic                   tab_hit;
   logic [CW-1:0]          tab_col;
   logic [CW-1:0]          col_a;
   logic [RW-1:0]          row_a;
   logic [CW-1:0]          col_b;
   logic [CW-1:0]          col_in;
   logic [RW-1:0]          row_c;
   logic [RW-1:0]          row_in;
   logic                   draw;
   logic                   advance;
   logic [CHAR_W-1:0]      draw_ch;
   logic                   scroll;
   logic [ADDR_W-1:0]      draw_addr;
   logic                   rsp_free;

   // next tab stop strictly right of the cursor
   always_comb begin
      tab_hit = 1'b0;
      tab_col = '0;
      for (int k = 1; k <= TAB_LAST; k++) begin
         if (!tab_hit && (k * TAB_STOP > int'(col_ff))) begin
            tab_hit = 1'b1;
            tab_col = CW'(k * TAB_STOP);
         end
      end
   end

   always_comb begin
      col_a   = col_ff;
      row_a   = row_ff;
      draw    = 1'b0;
      advance = 1'b0;
      draw_ch = ch_ff;
      case (ch_ff) inside
         CH_BS: begin
            if (col_ff != '0) begin
               col_a = col_ff - CW'(1);
            end
            draw    = 1'b1;
            draw_ch = CH_SPACE;
         end
         CH_TAB: begin
            if (tab_hit) begin
               col_a = tab_col;
            end else begin
               col_a = '0;
               row_a = row_ff + RW'(1);
            end
         end
         CH_CR: begin
            col_a = '0;
         end
         CH_LF: begin
            col_a = '0;
            row_a = row_ff + RW'(1);
         end
         [CH_PRINT_LO:CH_PRINT_HI]: begin
            draw    = 1'b1;
            advance = 1'b1;
         end
         default: begin
         end
      endcase
      col_b = col_a + CW'(advance);
      if (col_b == CW'(COLUMNS)) begin
         col_in = '0;
         row_c  = row_a + RW'(1);
      end else begin
         col_in = col_b;
         row_c  = row_a;
      end
      scroll    = (row_c == RW'(ROWS));
      row_in    = scroll ? RW'(ROWS - 1) : row_c;
      draw_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_a));
   end

   // write port: sweeps, draw, scroll copy, then bottom-line fill
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data = '0;
      ram_rd_addr = ADDR_W'(idx_ff);
      if (state_ff == S_SCROLL) begin
         ram_rd_addr = ADDR_W'(cnt_ff + ADDR_W'(COLUMNS));
      end
      if (cp_vld_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cp_addr_ff;
         ram_wr_data = ram_rd_data;
      end else begin
         case (state_ff)
            S_INIT, S_CLEAR: begin
               ram_wr_en = 1'b1;
            end
            S_EXEC: begin
               ram_wr_en   = (op_ff == OP_PUT) && draw;
               ram_wr_addr = draw_addr;
               ram_wr_data = {attr_ff, draw_ch};
            end
            S_FILL: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {attr_ff, CH_SPACE};
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         op_ff           <= OP_PUT;
         ch_ff           <= '0;
         idx_ff          <= '0;
         attr_ff         <= ATTR_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         cnt_ff          <= '0;
         cp_vld_ff       <= 1'b0;
         cp_addr_ff      <= '0;
         cell_ff         <= '0;
         scrolled_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_col_ff      <= '0;
         rsp_row_ff      <= '0;
         rsp_cell_ff     <= '0;
         rsp_scrolled_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         cp_vld_ff  <= (state_ff == S_SCROLL);
         cp_addr_ff <= cnt_ff;
         case (state_ff)
            S_INIT: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == ADDR_W'(CELL_LAST)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= opcode_type'(req_opcode);
                  ch_ff    <= req_char_code;
                  idx_ff   <= req_cell_index;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               cell_ff     <= '0;
               scrolled_ff <= (op_ff == OP_PUT) && scroll;
               cnt_ff      <= '0;
               case (op_ff)
                  OP_PUT: begin
                     col_ff      <= col_in;
                     row_ff      <= row_in;
                     state_ff    <= scroll ? S_SCROLL : S_EMIT;
                  end
                  OP_CLEAR: begin
                     col_ff   <= '0;
                     row_ff   <= '0;
                     state_ff <= S_CLEAR;
                  end
                  OP_READ: begin
                     state_ff <= S_READ;
                  end
                  default: begin
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_READ: begin
               cell_ff  <= (int'(idx_ff) < CELL_COUNT) ? ram_rd_data : '0;
               state_ff <= S_EMIT;
            end
            S_SCROLL: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == ADDR_W'(COPY_LAST)) begin
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               if (!cp_vld_ff) begin
                  cnt_ff <= cnt_ff + ADDR_W'(1);
                  if (cnt_ff == ADDR_W'(CELL_LAST)) begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_CLEAR: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == ADDR_W'(CELL_LAST)) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_col_ff      <= COL_OUT_W'(col_ff);
                  rsp_row_ff      <= ROW_OUT_W'(row_ff);
                  rsp_cell_ff     <= cell_ff;
                  rsp_scrolled_ff <= scrolled_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

// ----- verif/text_console_char_writer_checker.sv -----
// Scoreboard for the text console character writer: mirrors the cell store,
// cursor and attribute, predicts every response word and compares it.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module text_console_char_writer_checker
   import tccw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [INDEX_W-1:0]   req_cell_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [COL_OUT_W-1:0] rsp_cursor_col,
   input  logic [ROW_OUT_W-1:0] rsp_cursor_row,
   input  logic [CELL_W-1:0]    rsp_cell_value,
   input  logic                 rsp_scrolled,
   input  logic                 csr_wr_en,
   input  logic [ATTR_W-1:0]    csr_wr_data,
   output int                   fail_count,
   output int                   pending_count
);

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 4;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   typedef struct packed {
      logic [COL_OUT_W-1:0] col;
      logic [ROW_OUT_W-1:0] row;
      logic [CELL_W-1:0]    cell_word;
      logic                 scrolled;
   } console_report_type;

   logic [CELL_W-1:0]  mirror_cells [CELL_COUNT];
   int                 mirror_col;
   int                 mirror_row;
   logic [ATTR_W-1:0]  mirror_attr;
   console_report_type console_reports [$];

   function automatic void home_and_blank();
      for (int i = 0; i < CELL_COUNT; i++) begin
         mirror_cells[i] = '0;
      end
      mirror_col = 0;
      mirror_row = 0;
   endfunction

   function automatic void scroll_mirror();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
         mirror_cells[i] = mirror_cells[i + COLUMNS];
      end
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
         mirror_cells[i] = {mirror_attr, CH_SPACE};
      end
   endfunction

   function automatic logic put_byte(logic [CHAR_W-1:0] code_in);
      logic [CHAR_W-1:0] code;
      int                step;
      logic              draw;
      int                next_stop;
      code = code_in;
      step = 1;
      draw = (code >= CH_PRINT_LO) && (code <= CH_PRINT_HI);
      if (code == CH_BS) begin
         if (mirror_col > 0) begin
            mirror_col = mirror_col - 1;
         end
         code = CH_SPACE;
         step = 0;
         draw = 1'b1;
      end else if (code == CH_TAB) begin
         next_stop = mirror_col + TAB_STOP;
         next_stop = next_stop - (next_stop % TAB_STOP);
         if (next_stop < COLUMNS) begin
            mirror_col = next_stop;
         end else begin
            mirror_col = 0;
            mirror_row = mirror_row + 1;
         end
      end else if (code == CH_CR) begin
         mirror_col = 0;
      end else if (code == CH_LF) begin
         mirror_col = 0;
         mirror_row = mirror_row + 1;
      end
      if (draw && mirror_row < ROWS && mirror_col < COLUMNS) begin
         mirror_cells[mirror_row * COLUMNS + mirror_col] = {mirror_attr, code};
         mirror_col = mirror_col + step;
      end
      if (mirror_col >= COLUMNS) begin
         mirror_col = 0;
         mirror_row = mirror_row + 1;
      end
      if (mirror_row >= ROWS) begin
         scroll_mirror();
         mirror_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_report_type predict_console_step(logic [OPCODE_W-1:0] op,
                                                               logic [CHAR_W-1:0] code,
                                                               logic [INDEX_W-1:0] idx);
      console_report_type rep;
      rep = '0;
      case (op)
         OP_PUT: begin
            rep.scrolled = put_byte(code);
         end
         OP_CLEAR: begin
            home_and_blank();
         end
         OP_READ: begin
            if (idx < CELL_COUNT) begin
               rep.cell_word = mirror_cells[idx];
            end
         end
         default: begin
         end
      endcase
      rep.col = COL_OUT_W'(mirror_col);
      rep.row = ROW_OUT_W'(mirror_row);
      return rep;
   endfunction

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d actual %0d", $time, label, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      console_report_type want;
      if (reset) begin
         home_and_blank();
         mirror_attr = ATTR_RESET;
         console_reports.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (console_reports.size() == 0) begin
               $display("%0t: response word with nothing pending: col %0d row %0d cell %h",
                        $time, rsp_cursor_col, rsp_cursor_row, rsp_cell_value);
               fail_count++;
            end else begin
               want = console_reports.pop_front();
               check_field("cursor_col", 32'(want.col), 32'(rsp_cursor_col));
               check_field("cursor_row", 32'(want.row), 32'(rsp_cursor_row));
               check_field("cell_value", 32'(want.cell_word), 32'(rsp_cell_value));
               check_field("scrolled", 32'(want.scrolled), 32'(rsp_scrolled));
            end
         end
         if (req_valid && !req_stall) begin
            console_reports.push_back(predict_console_step(req_opcode, req_char_code,
                                                           req_cell_index));
         end
         if (csr_wr_en) begin
            mirror_attr = csr_wr_data;
         end
      end
      pending_count = console_reports.size();
   end

endmodule

// ----- verif/text_console_char_writer_tb.sv -----
// Top of the text console character writer bench: clock, reset, stimulus,
// idling and the verdict. Depends on tccw_pkg, the block and its checker.
`timescale 1ns / 1ps

module text_console_char_writer_tb;
   import tccw_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_WORDS   = 460;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 10000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OPCODE_W-1:0]  req_opcode = '0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COL_OUT_W-1:0] rsp_cursor_col;
   logic [ROW_OUT_W-1:0] rsp_cursor_row;
   logic [CELL_W-1:0]    rsp_cell_value;
   logic                 rsp_scrolled;
   logic                 csr_wr_en = 1'b0;
   logic [ATTR_W-1:0]    csr_wr_data = '0;

   int   fail_count;
   int   pending_count;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   words_sent = 0;
   int   hold_left = 0;
   int   cycle_count = 0;
   logic hold_request = 1'b0;
   logic hold_served = 1'b0;

   text_console_char_writer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   text_console_char_writer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[text_console_char_writer] ERROR");
         $finish;
      end
   end

   // hold off the response side once for a long stretch, else stall at random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] code,
                            input logic [INDEX_W-1:0] idx);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_char_code  <= code;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic set_text_attribute(input logic [ATTR_W-1:0] attr);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= attr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
         return CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      end else if (pick < 89) begin
         return CH_TAB;
      end else if (pick < 93) begin
         return CH_BS;
      end
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [INDEX_W-1:0] read_index();
      if ($urandom_range(0, 9) == 0) begin
         return INDEX_W'($urandom_range(2000, 2047));
      end
      return INDEX_W'($urandom_range(0, 1999));
   endfunction

   task automatic random_burst();
      int pick;
      int count;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // short fragment or a long line that can wrap
         count = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(60, 100);
         repeat (count) send_word(OP_PUT, text_byte(), INDEX_W'($urandom_range(0, 2047)));
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_word(OP_PUT, CH_LF, INDEX_W'($urandom_range(0, 2047)));
         end else if (pick < 8) begin
            send_word(OP_PUT, CH_CR, INDEX_W'($urandom_range(0, 2047)));
         end
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 4)) begin
            send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), read_index());
         end
      end else if (pick < 90) begin
         send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, 2047)));
      end else if (pick < 94) begin
         send_word(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, 2047)));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            send_word(OPCODE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2047)));
         end
      end
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct);
      int first;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
         random_burst();
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_word(OP_READ, 8'h00, 11'd0);
      send_word(OP_PUT, 8'd65, 11'd0);
      send_word(OP_PUT, CH_PRINT_LO, 11'h7FF);
      send_word(OP_PUT, CH_PRINT_HI, 11'd0);
      send_word(OP_PUT, 8'd0, 11'd0);
      send_word(OP_PUT, 8'd31, 11'd0);
      send_word(OP_PUT, 8'd128, 11'd0);
      send_word(OP_PUT, 8'd255, 11'd0);
      send_word(OP_PUT, CH_BS, 11'd0);
      send_word(OP_PUT, CH_TAB, 11'd0);
      send_word(OP_PUT, CH_CR, 11'd0);
      send_word(OP_PUT, CH_BS, 11'd0);
      send_word(OP_PUT, CH_LF, 11'd0);
      send_word(OP_READ, 8'hFF, 11'd0);
      send_word(OP_READ, 8'h00, 11'd1);
      send_word(OP_READ, 8'h00, 11'd1999);
      send_word(OP_READ, 8'h00, 11'd2000);
      send_word(OP_READ, 8'h00, 11'd2047);
      send_word(OP_UNUSED, 8'hFF, 11'h7FF);
      send_word(OP_CLEAR, 8'h00, 11'd0);
      send_word(OP_READ, 8'h00, 11'd0);

      set_text_attribute(8'h00);
      run_phase(7, 77);
      set_text_attribute(8'hFF);
      run_phase(77, 7);
      set_text_attribute(ATTR_W'($urandom_range(1, 254)));
      hold_request = 1'b1;
      run_phase(0, 0);

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[text_console_char_writer] OK");
      end else begin
         $display("[text_console_char_writer] ERROR");
      end
      $finish;
   end

endmodule
